/* design/mcoc_pkg.sv */
// ---------------------------------------------------------------------------
// mcoc_pkg: shared types and constants for the matrix chain cost block
// beat layouts, status codes, sizes and the control bundle to the evaluator
// ---------------------------------------------------------------------------
package mcoc_pkg;

  localparam int MAX_MATRICES = 16;
  localparam int DIM_BITS     = 16;
  localparam int STORE_DEPTH  = MAX_MATRICES + 1;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int COST_W       = 52;
  localparam int PROD_W       = 3 * DIM_BITS;
  localparam int ACC_W        = COST_W + 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic [15:0] dim;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic                lr_load;
    logic [DIM_BITS-1:0] dl;
    logic [DIM_BITS-1:0] dr;
    logic                valid;
    logic                first;
    logic                fin;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    s;
    logic [IDX_W-1:0]    b;
    logic [DIM_BITS-1:0] ds;
  } ev_ctl_t;

  typedef struct packed {
    logic              wr_done;
    logic [COST_W-1:0] wr_val;
  } ev_res_t;

endpackage

/* design/mcoc_cell.sv */
// ---------------------------------------------------------------------------
// mcoc_cell: one position of the two dimension rings
// loads a dimension in place, or takes its neighbor's value on rotation
// ---------------------------------------------------------------------------
module mcoc_cell (
  input  logic                         clk,
  input  logic                         load,
  input  logic [mcoc_pkg::DIM_BITS-1:0] load_val,
  input  logic                         rot1,
  input  logic                         rot2,
  input  logic [mcoc_pkg::DIM_BITS-1:0] nb1,
  input  logic [mcoc_pkg::DIM_BITS-1:0] nb2,
  output logic [mcoc_pkg::DIM_BITS-1:0] v1,
  output logic [mcoc_pkg::DIM_BITS-1:0] v2
);
  import mcoc_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      v1 <= load_val;
      v2 <= load_val;
    end else begin
      if (rot1) v1 <= nb1;
      if (rot2) v2 <= nb2;
    end
  end

endmodule

/* design/mcoc_eval.sv */
// ---------------------------------------------------------------------------
// mcoc_eval: split evaluation pipeline and cost table
// three stages: table read, partial sums and product, compare and write back
// ---------------------------------------------------------------------------
module mcoc_eval (
  input  logic              clk,
  input  logic              rst,
  input  mcoc_pkg::ev_ctl_t ctl,
  output mcoc_pkg::ev_res_t res
);
  import mcoc_pkg::*;

  logic [COST_W-1:0]     mem [STORE_DEPTH][STORE_DEPTH];
  logic [IDX_W-1:0]      s_p1;
  logic [2*DIM_BITS-1:0] plr;
  // stage 1
  logic                  v1, f1, fin1, ldiag, rdiag;
  logic [COST_W-1:0]     ql, qr;
  logic [DIM_BITS-1:0]   ds1;
  logic [IDX_W-1:0]      a1, b1;
  // stage 2
  logic                  v2, f2, fin2;
  logic [ACC_W-1:0]      csum;
  logic [PROD_W-1:0]     prod;
  logic [IDX_W-1:0]      a2, b2;
  // stage 3
  logic [ACC_W-1:0]      cand, best, best_next;
  logic [COST_W-1:0]     sat;
  logic                  wr_done;
  logic [COST_W-1:0]     wr_val;

  assign s_p1 = ctl.s + IDX_W'(1);
  assign res  = {wr_done, wr_val};

  always_ff @(posedge clk) begin
    if (ctl.lr_load) plr <= ctl.dl * ctl.dr;
    if (ctl.valid) begin
      ql <= mem[ctl.a][ctl.s];
      qr <= mem[s_p1][ctl.b];
    end
    ldiag <= (ctl.s == ctl.a);
    rdiag <= (s_p1 == ctl.b);
    ds1   <= ctl.ds;
    f1    <= ctl.first;
    fin1  <= ctl.fin;
    a1    <= ctl.a;
    b1    <= ctl.b;
    csum  <= ACC_W'(ldiag ? '0 : ql) + ACC_W'(rdiag ? '0 : qr);
    prod  <= plr * ds1;
    f2    <= f1;
    fin2  <= fin1;
    a2    <= a1;
    b2    <= b1;
  end

  // single-span minimum, saturated into the table width
  assign cand      = csum + ACC_W'(prod);
  assign best_next = (f2 || cand < best) ? cand : best;
  assign sat       = (best_next > ACC_W'(COST_MAX)) ? COST_MAX : best_next[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (v2) best <= best_next;
    if (v2 && fin2) begin
      mem[a2][b2] <= sat;
      wr_val      <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      wr_done <= 1'b0;
    end else begin
      v1      <= ctl.valid;
      v2      <= v1;
      wr_done <= v2 && fin2;
    end
  end

endmodule

/* design/matrix_chain_order_cost_top.sv */
// ---------------------------------------------------------------------------
// matrix_chain_order_cost_top: least multiplication count of a matrix chain
// collects the dimension sequence, then fills the span cost table by length
// ---------------------------------------------------------------------------
//
//  channel  handshake        payload   direction
//  item     start / busy     item_t    in, one dimension per beat
//  result   done (strobe)    result_t  out, one beat per last item
//
//  a dimension beat is taken while busy is low; beats that are
//  not last give no result and keep busy low
//  on a last beat with a chain of n >= 2 matrices the block goes busy and
//  walks every span; for each span it rotates the 17-cell dimension ring
//  until d(a-1) is at its head, then evaluates one split point per cycle,
//  and after the last span it drains the evaluator pipeline
//  error and single-matrix chains give their result the cycle after the beat
//  synchronous reset clears the controller, counts and strobe; the stores
//  need no clearing since only entries written in the current chain are read
//  the receiver cannot stall: done is high for exactly one cycle
// ---------------------------------------------------------------------------
module matrix_chain_order_cost_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mcoc_pkg::item_t   item,
  output logic              done,
  output mcoc_pkg::result_t result
);
  import mcoc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALIGN = 5'b00010,
    S_SEEK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [IDX_W-1:0]   nmat, len, a, s, h;
  logic [1:0]         align_cnt;

  // dimension rings: ring 1 head is d(h), ring 2 head runs len+1 ahead
  logic [DIM_BITS-1:0] r1 [STORE_DEPTH];
  logic [DIM_BITS-1:0] r2 [STORE_DEPTH];
  logic                rot1, rot2, accept, full;
  logic [IDX_W-1:0]    b;
  logic [CNT_W-1:0]    cnt_new;
  ev_ctl_t             ctl;
  ev_res_t             res;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count == CNT_W'(STORE_DEPTH));
  assign cnt_new = full ? count : count + CNT_W'(1);
  assign b       = a + len;

  assign rot1 = (state == S_SEEK) || (state == S_EVAL);
  assign rot2 = rot1 || (state == S_ALIGN);

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_ring
    mcoc_cell u_cell (
      .clk      (clk),
      .load     (accept && !full && count[IDX_W-1:0] == IDX_W'(i)),
      .load_val (item.dim[DIM_BITS-1:0]),
      .rot1     (rot1),
      .rot2     (rot2),
      .nb1      (r1[(i + 1) % STORE_DEPTH]),
      .nb2      (r2[(i + 1) % STORE_DEPTH]),
      .v1       (r1[i]),
      .v2       (r2[i])
    );
  end

  // control bundle for the split evaluator
  always_comb begin
    ctl         = '0;
    ctl.lr_load = (state == S_SEEK) && (h == a - IDX_W'(1));
    ctl.dl      = r1[0];
    ctl.dr      = r2[0];
    ctl.valid   = (state == S_EVAL);
    ctl.first   = (s == a);
    ctl.fin     = (s == b - IDX_W'(1));
    ctl.a       = a;
    ctl.s       = s;
    ctl.b       = b;
    ctl.ds      = r1[0];
  end

  mcoc_eval u_eval (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .res (res)
  );

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && item.last) begin
      result.min_cost <= '0;
      if (ovf || full)                       result.status <= ST_LONG;
      else if (cnt_new < CNT_W'(2))          result.status <= ST_SHORT;
      else                                   result.status <= ST_OK;
    end else if (state == S_FIN && res.wr_done) begin
      result.min_cost <= res.wr_val;
      result.status   <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      done      <= 1'b0;
      nmat      <= '0;
      len       <= '0;
      a         <= '0;
      s         <= '0;
      h         <= '0;
      align_cnt <= '0;
    end else begin
      // long and short chains, and a single matrix, answer at once
      done <= (accept && item.last && (ovf || full || cnt_new <= CNT_W'(2)))
              || (state == S_FIN && res.wr_done);
      if (rot1) h <= (h == IDX_W'(STORE_DEPTH - 1)) ? '0 : h + IDX_W'(1);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.last) begin
              count <= '0;
              ovf   <= 1'b0;
              if (!(ovf || full || cnt_new <= CNT_W'(2))) begin
                nmat      <= IDX_W'(cnt_new - CNT_W'(1));
                len       <= IDX_W'(1);
                a         <= IDX_W'(1);
                h         <= '0;
                align_cnt <= 2'd2;
                state     <= S_ALIGN;
              end
            end else begin
              count <= cnt_new;
              ovf   <= ovf || full;
            end
          end
        end
        S_ALIGN: begin
          if (align_cnt == 2'd1) state <= S_SEEK;
          align_cnt <= align_cnt - 2'd1;
        end
        S_SEEK: begin
          if (h == a - IDX_W'(1)) begin
            s     <= a;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          s <= s + IDX_W'(1);
          if (s == b - IDX_W'(1)) begin
            if (a < nmat - len) begin
              a     <= a + IDX_W'(1);
              state <= S_SEEK;
            end else if (len < nmat - IDX_W'(1)) begin
              len       <= len + IDX_W'(1);
              a         <= IDX_W'(1);
              align_cnt <= 2'd1;
              state     <= S_ALIGN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          // last span written back: that entry is the whole-chain cost
          if (res.wr_done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* test/matrix_chain_order_cost_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_chain_order_cost_checker: chain cost scoreboard
// watches dimension beats, predicts the least multiplication count of each
// chain and compares it with every result beat
// ---------------------------------------------------------------------------
module matrix_chain_order_cost_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  mcoc_pkg::item_t   item,
  input  logic              done,
  input  mcoc_pkg::result_t result,
  output int                fail_count,
  output int                pending
);
  import mcoc_pkg::*;

  typedef logic [63:0] cost64_t;

  logic [DIM_BITS-1:0] chain_dims [STORE_DEPTH];
  int                  chain_len;
  logic                chain_over;
  result_t             expected_results [$];

  function automatic cost64_t best_cost(input int nmat);
    cost64_t span [STORE_DEPTH][STORE_DEPTH];
    cost64_t c;
    int b;
    for (int a = 0; a <= nmat; a++)
      for (int j = 0; j <= nmat; j++)
        span[a][j] = (a == j) ? 64'd0 : (64'd1 << 60);
    for (int len = 1; len <= nmat; len++) begin
      for (int a = 1; a + len <= nmat; a++) begin
        b = a + len;
        for (int s = a; s < b; s++) begin
          c = span[a][s] + span[s+1][b] + 64'(chain_dims[a-1]) * 64'(chain_dims[s])
              * 64'(chain_dims[b]);
          if (c < span[a][b]) span[a][b] = c;
        end
      end
    end
    return span[1][nmat];
  endfunction

  task automatic report(input string what);
    $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t r;
    cost64_t c;
    if (rst) begin
      chain_len  = 0;
      chain_over = 1'b0;
      fail_count = 0;
    end else begin
      // result beat, compared first against the oldest expectation
      if (done) begin
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          r = expected_results.pop_front();
          if (result.status !== r.status)
            report($sformatf("status got %0d want %0d", result.status, r.status));
          if (result.min_cost !== r.min_cost)
            report($sformatf("min_cost got %0d want %0d", result.min_cost, r.min_cost));
        end
      end
      // dimension beat
      if (start && !busy) begin
        if (chain_len < STORE_DEPTH) begin
          chain_dims[chain_len] = item.dim[DIM_BITS-1:0];
          chain_len = chain_len + 1;
        end else begin
          chain_over = 1'b1;
        end
        if (item.last) begin
          r = '0;
          if (chain_over) begin
            r.status = ST_LONG;
          end else if (chain_len < 2) begin
            r.status = ST_SHORT;
          end else begin
            c = best_cost(chain_len - 1);
            r.status   = ST_OK;
            r.min_cost = (c > 64'(COST_MAX)) ? COST_MAX : c[COST_W-1:0];
          end
          expected_results = {expected_results, r};
          chain_len  = 0;
          chain_over = 1'b0;
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

/* test/matrix_chain_order_cost_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_chain_order_cost_top_tb: matrix chain cost testbench
// drives directed and random chains with random idle gaps; the checker
// predicts every result and counts mismatches
// ---------------------------------------------------------------------------
module matrix_chain_order_cost_top_tb;
  import mcoc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      fail_count;
  int      pending;
  int      cycle_count;
  bit      quiet_stretch;  // no idle gaps while set

  matrix_chain_order_cost_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  matrix_chain_order_cost_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on total cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one dimension beat: optional idle gap, then hold start until accepted
  task automatic send_dim(input logic [15:0] d, input logic lst);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start     <= 1'b1;
    item.dim  <= d;
    item.last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // whole chain of n dimensions; mode picks the dimension spread
  task automatic send_chain(input int n, input int mode);
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: d = 16'($urandom_range(1, 16));
        1: d = 16'($urandom_range(1, 65535));
        2: d = $urandom_range(1) ? 16'hffff : 16'($urandom);
        default: d = 16'($urandom);  // zero allowed here
      endcase
      send_dim(d, i == n - 1);
    end
  endtask

  // drop start first so the checker has seen the last beat, then wait until nothing is pending
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  int sent;
  int n;

  initial begin
    cycle_count   = 0;
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    quiet_stretch = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single dimension, pair, extremes of the field
    send_dim(16'd7, 1'b1);
    send_dim(16'd1, 1'b0);
    send_dim(16'd1, 1'b1);
    send_dim(16'hffff, 1'b0);
    send_dim(16'hffff, 1'b0);
    send_dim(16'hffff, 1'b1);
    // zero dimension inside a chain
    send_dim(16'd5, 1'b0);
    send_dim(16'd0, 1'b0);
    send_dim(16'd9, 1'b1);
    // full store: 17 dimensions, each either the maximum or a random value
    send_chain(STORE_DEPTH, 2);
    // store overflow: 18 dimensions gives the too-many status
    send_chain(STORE_DEPTH + 1, 0);
    // sender waits until the pipeline is empty
    drain();

    sent = 0;
    while (sent < 1350) begin
      quiet_stretch = (sent > 600 && sent < 750);
      case ($urandom_range(19))
        0:       n = 1;
        1:       n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
        2:       n = STORE_DEPTH;
        default: n = $urandom_range(2, 6);
      endcase
      send_chain(n, $urandom_range(3));
      sent += n;
      if ($urandom_range(40) == 0) drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* sim.f */
design/mcoc_pkg.sv
design/mcoc_cell.sv
design/mcoc_eval.sv
design/matrix_chain_order_cost_top.sv
test/matrix_chain_order_cost_checker.sv
test/matrix_chain_order_cost_top_tb.sv
